@@ rtl/thsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Tag header stream decoder package
// Shared payload types and result codes for the tag header stream decoder.
// ----------------------------------------------------------------------------
package thsd_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_HDR_PEND = 2'd0;
  localparam logic [1:0] KIND_HDR_DONE = 2'd1;
  localparam logic [1:0] KIND_VALUE    = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Tag marks.
  localparam logic [1:0] MARK_NONE  = 2'd0;
  localparam logic [1:0] MARK_OPEN  = 2'd1;
  localparam logic [1:0] MARK_CLOSE = 2'd2;

  // One input byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } thsd_in_t;

  // One decoded result.
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         tag_number;
    logic               is_context;
    logic [1:0]         tag_mark;
    logic [31:0]        value_length;
    logic [7:0]         byte_out;
    logic [31:0]        value_index;
    logic               last;
    logic [31:0]        uint_value;
    logic signed [31:0] sint_value;
    logic               value_fits;
  } thsd_out_t;

endpackage

@@ rtl/thsd_core.sv @@
// ----------------------------------------------------------------------------
// Tag header stream decoder core
// Holds the parser state and decodes one byte per step into one result.
// ----------------------------------------------------------------------------
module thsd_core import thsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  thsd_in_t  in_item,
  output thsd_out_t res
);

  // Parser phases.
  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_EXT_TAG  = 3'd1;
  localparam logic [2:0] PH_LEN_BYTE = 3'd2;
  localparam logic [2:0] PH_EXT_LEN  = 3'd3;
  localparam logic [2:0] PH_VALUE    = 3'd4;

  localparam logic [7:0] LEN_EXT2 = 8'd254;

  logic [2:0]  phase_r,  phase_nxt;
  logic [7:0]  tag_r,    tag_nxt;
  logic        ctx_r,    ctx_nxt;
  logic [2:0]  lc_r,     lc_nxt;
  logic [2:0]  ext_r,    ext_nxt;
  logic [31:0] vlen_r,   vlen_nxt;
  logic [31:0] cnt_r,    cnt_nxt;
  logic [31:0] acc_r,    acc_nxt;

  logic [2:0]  ph;
  logic [7:0]  b;
  logic        do_decide;
  logic        do_complete;
  logic [31:0] cmp_len;
  logic [31:0] vlen_shift;

  assign b          = in_item.data_byte;
  assign ph         = in_item.restart ? PH_HEADER : phase_r;
  assign vlen_shift = {vlen_r[23:0], b};

  // Next state and result for the byte on the input.
  always_comb begin
    phase_nxt   = phase_r;
    tag_nxt     = tag_r;
    ctx_nxt     = ctx_r;
    lc_nxt      = lc_r;
    ext_nxt     = ext_r;
    vlen_nxt    = vlen_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    do_decide   = 1'b0;
    do_complete = 1'b0;
    cmp_len     = '0;
    res         = '0;
    res.kind    = KIND_HDR_PEND;

    if (ph == PH_EXT_TAG) begin
      tag_nxt   = b;
      do_decide = 1'b1;
    end else if (ph == PH_LEN_BYTE) begin
      if (b < LEN_EXT2) begin
        do_complete = 1'b1;
        cmp_len     = {24'd0, b};
      end else begin
        ext_nxt   = (b == LEN_EXT2) ? 3'd2 : 3'd4;
        vlen_nxt  = '0;
        phase_nxt = PH_EXT_LEN;
      end
    end else if (ph == PH_EXT_LEN) begin
      vlen_nxt = vlen_shift;
      ext_nxt  = ext_r - 3'd1;
      if (ext_nxt == 3'd0) begin
        do_complete = 1'b1;
        cmp_len     = vlen_shift;
      end
    end else if (ph == PH_VALUE) begin
      // Value byte: shift into the accumulator and count it.
      acc_nxt          = {acc_r[23:0], b};
      cnt_nxt          = cnt_r + 32'd1;
      res.kind         = KIND_VALUE;
      res.value_length = vlen_r;
      res.value_index  = cnt_r;
      res.uint_value   = acc_nxt;
      res.value_fits   = (vlen_r >= 32'd1) && (vlen_r <= 32'd4);
      if (cnt_nxt[31:2] != 30'd0) begin
        res.sint_value = acc_nxt;
      end else begin
        case (cnt_nxt[1:0])
          2'd1:    res.sint_value = {{24{acc_nxt[7]}}, acc_nxt[7:0]};
          2'd2:    res.sint_value = {{16{acc_nxt[15]}}, acc_nxt[15:0]};
          2'd3:    res.sint_value = {{8{acc_nxt[23]}}, acc_nxt[23:0]};
          default: res.sint_value = acc_nxt;
        endcase
      end
      if (cnt_nxt == vlen_r) begin
        res.last  = 1'b1;
        phase_nxt = PH_HEADER;
      end
    end else begin
      // First header byte: tag nibble, class bit and length code.
      tag_nxt  = {4'd0, b[7:4]};
      ctx_nxt  = b[3];
      lc_nxt   = b[2:0];
      vlen_nxt = '0;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      ext_nxt  = '0;
      if (b[7:4] == 4'hf) begin
        phase_nxt = PH_EXT_TAG;
      end else begin
        do_decide = 1'b1;
      end
    end

    // Tag number and class known: act on the length code.
    if (do_decide) begin
      if (!ctx_nxt && tag_nxt == 8'd1) begin
        phase_nxt      = PH_HEADER;
        vlen_nxt       = '0;
        res.kind       = KIND_HDR_DONE;
        res.last       = 1'b1;
        res.uint_value = {31'd0, lc_nxt[0]};
        res.sint_value = {31'd0, lc_nxt[0]};
        res.value_fits = 1'b1;
      end else if (lc_nxt == 3'd6 || lc_nxt == 3'd7) begin
        phase_nxt = PH_HEADER;
        vlen_nxt  = '0;
        res.last  = 1'b1;
        if (ctx_nxt) begin
          res.kind     = KIND_HDR_DONE;
          res.tag_mark = (lc_nxt == 3'd6) ? MARK_OPEN : MARK_CLOSE;
        end else begin
          res.kind = KIND_ERROR;
        end
      end else if (lc_nxt == 3'd5) begin
        phase_nxt = PH_LEN_BYTE;
      end else begin
        do_complete = 1'b1;
        cmp_len     = {29'd0, lc_nxt};
      end
    end

    // Header complete with a known length.
    if (do_complete) begin
      vlen_nxt = cmp_len;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      res.kind = KIND_HDR_DONE;
      if (cmp_len == 32'd0) begin
        phase_nxt = PH_HEADER;
        res.last  = 1'b1;
      end else begin
        phase_nxt        = PH_VALUE;
        res.value_length = cmp_len;
        res.value_fits   = (cmp_len >= 32'd1) && (cmp_len <= 32'd4);
      end
    end

    res.tag_number = tag_nxt;
    res.is_context = ctx_nxt;
    res.byte_out   = b;
  end

  // Parser state advances on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      tag_r   <= '0;
      ctx_r   <= 1'b0;
      lc_r    <= '0;
      ext_r   <= '0;
      vlen_r  <= '0;
      cnt_r   <= '0;
      acc_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      ctx_r   <= ctx_nxt;
      lc_r    <= lc_nxt;
      ext_r   <= ext_nxt;
      vlen_r  <= vlen_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

@@ rtl/tag_header_stream_decoder_top.sv @@
// Each result is registered, in the result register or the skid register, as its byte is accepted.
// Throughput: one byte per cycle while the skid register is empty; each byte is one pass through the decode logic.
// A two-entry output stage (result register plus skid register) keeps input
// flowing while the output is stalled, until the skid register fills.
// Reset (synchronous, rst_n low) empties the output stage and returns the
// parser to the header phase with all state cleared.
// ----------------------------------------------------------------------------
// Tag header stream decoder top level
// Decodes a stream of tagged-field bytes, one result transfer per byte.
// ----------------------------------------------------------------------------
module tag_header_stream_decoder_top import thsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  thsd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output thsd_out_t out_data
);

  thsd_out_t res;
  thsd_out_t out_r;
  thsd_out_t skid_r;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  logic      step;
  logic      out_free;

  assign in_ready  = !skid_valid_r;
  assign step      = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  thsd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_item (in_data),
    .res     (res)
  );

  // Output stage occupancy.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = step;
      end
    end else if (step) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payloads.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (step) begin
        out_r <= res;
      end
    end else if (step) begin
      skid_r <= res;
    end
  end

  // The skid register is only ever filled behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while result register empty");

  // An accepted byte always leaves the result register full on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted byte produced no result");

  // A byte accepted while the output is stalled fills the skid and stops the input.
  a_full_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && step) |=> !in_ready)
    else $error("input still open with both output entries full");

  // Errors always close the tag.
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_ERROR) |-> out_r.last)
    else $error("error result without last marker");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag header stream decoder testbench
// Sends encoded tag streams one byte per transfer, decodes each byte with an
// independent model of the parser and compares every result transfer, field by
// field, against the oldest decoded result still awaited.
// ----------------------------------------------------------------------------
module tb;
  import thsd_pkg::*;

  // Parser positions within a tag.
  typedef enum logic [2:0] {
    AT_HEADER,
    AT_EXT_TAG,
    AT_LEN_BYTE,
    AT_EXT_LEN,
    AT_VALUE
  } parse_phase_t;

  localparam int         IDLE_PCT        = 21;
  localparam logic [3:0] EXT_TAG_NIBBLE  = 4'hF;
  localparam logic [2:0] CODE_LEN_BYTE   = 3'd5;
  localparam logic [2:0] CODE_OPEN       = 3'd6;
  localparam logic [2:0] CODE_CLOSE      = 3'd7;
  localparam logic [7:0] LEN_TWO_BYTES   = 8'd254;
  localparam logic [7:0] LEN_FOUR_BYTES  = 8'd255;
  localparam logic [7:0] BOOLEAN_TAG     = 8'd1;

  // Ways of encoding a length behind length code five.
  localparam logic [1:0] FORM_BYTE = 2'd0;
  localparam logic [1:0] FORM_TWO  = 2'd1;
  localparam logic [1:0] FORM_FOUR = 2'd2;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  thsd_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  thsd_out_t out_data;

  int sender_idle_pct    = IDLE_PCT;
  int receiver_stall_pct = IDLE_PCT;
  int mismatch_count     = 0;
  int bytes_sent         = 0;

  // Decoded results awaiting their transfer from the block, oldest first.
  thsd_out_t decoded_results[$];

  // Parser state of the model, cleared as after reset.
  parse_phase_t phase            = AT_HEADER;
  logic [7:0]   cur_tag          = '0;
  logic         cur_context      = 1'b0;
  logic [2:0]   cur_len_code     = '0;
  logic [2:0]   len_bytes_left   = '0;
  logic [31:0]  cur_value_len    = '0;
  logic [31:0]  value_bytes_seen = '0;
  logic [31:0]  value_accum      = '0;

  always #6 clk = ~clk;

  tag_header_stream_decoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic logic length_fits(input logic [31:0] len);
    return (len >= 32'd1) && (len <= 32'd4);
  endfunction

  function automatic thsd_out_t make_result(
    input logic [1:0]  kind,
    input logic [1:0]  mark,
    input logic [31:0] len,
    input logic [7:0]  data,
    input logic [31:0] index,
    input logic        last,
    input logic [31:0] uval,
    input logic [31:0] sval,
    input logic        fits
  );
    thsd_out_t r;
    r.kind         = kind;
    r.tag_number   = cur_tag;
    r.is_context   = cur_context;
    r.tag_mark     = mark;
    r.value_length = len;
    r.byte_out     = data;
    r.value_index  = index;
    r.last         = last;
    r.uint_value   = uval;
    r.sint_value   = sval;
    r.value_fits   = fits;
    return r;
  endfunction

  // The length is known: an empty tag ends here, otherwise value bytes follow.
  function automatic thsd_out_t start_value(input logic [31:0] len, input logic [7:0] data);
    cur_value_len    = len;
    value_bytes_seen = '0;
    value_accum      = '0;
    if (len == 32'd0) begin
      phase = AT_HEADER;
      return make_result(KIND_HDR_DONE, MARK_NONE, '0, data, '0, 1'b1, '0, '0, 1'b0);
    end
    phase = AT_VALUE;
    return make_result(KIND_HDR_DONE, MARK_NONE, len, data, '0, 1'b0, '0, '0,
                       length_fits(len));
  endfunction

  // Tag number and class are settled; act on the length code.
  function automatic thsd_out_t apply_length_code(input logic [7:0] data);
    logic [31:0] flag;
    if (!cur_context && cur_tag == BOOLEAN_TAG) begin
      flag          = {31'd0, cur_len_code[0]};
      phase         = AT_HEADER;
      cur_value_len = '0;
      return make_result(KIND_HDR_DONE, MARK_NONE, '0, data, '0, 1'b1, flag, flag, 1'b1);
    end
    if (cur_len_code == CODE_OPEN || cur_len_code == CODE_CLOSE) begin
      phase         = AT_HEADER;
      cur_value_len = '0;
      if (cur_context) begin
        return make_result(KIND_HDR_DONE, (cur_len_code == CODE_OPEN) ? MARK_OPEN : MARK_CLOSE,
                           '0, data, '0, 1'b1, '0, '0, 1'b0);
      end
      return make_result(KIND_ERROR, MARK_NONE, '0, data, '0, 1'b1, '0, '0, 1'b0);
    end
    if (cur_len_code == CODE_LEN_BYTE) begin
      phase = AT_LEN_BYTE;
      return make_result(KIND_HDR_PEND, MARK_NONE, '0, data, '0, 1'b0, '0, '0, 1'b0);
    end
    return start_value({29'd0, cur_len_code}, data);
  endfunction

  // Advances the model by one byte and returns the result that it causes.
  function automatic thsd_out_t decode_byte(input thsd_in_t item);
    logic [7:0]  data;
    logic [31:0] index;
    logic [31:0] sval;
    int unsigned held;
    logic        last;
    data = item.data_byte;
    if (item.restart) phase = AT_HEADER;
    case (phase)
      AT_EXT_TAG: begin
        cur_tag = data;
        return apply_length_code(data);
      end
      AT_LEN_BYTE: begin
        if (data < LEN_TWO_BYTES) return start_value({24'd0, data}, data);
        len_bytes_left = (data == LEN_TWO_BYTES) ? 3'd2 : 3'd4;
        cur_value_len  = '0;
        phase          = AT_EXT_LEN;
        return make_result(KIND_HDR_PEND, MARK_NONE, '0, data, '0, 1'b0, '0, '0, 1'b0);
      end
      AT_EXT_LEN: begin
        cur_value_len  = {cur_value_len[23:0], data};
        len_bytes_left = len_bytes_left - 3'd1;
        if (len_bytes_left == 3'd0) return start_value(cur_value_len, data);
        return make_result(KIND_HDR_PEND, MARK_NONE, '0, data, '0, 1'b0, '0, '0, 1'b0);
      end
      AT_VALUE: begin
        index            = value_bytes_seen;
        value_accum      = {value_accum[23:0], data};
        value_bytes_seen = index + 32'd1;
        held             = (value_bytes_seen > 32'd4) ? 4 : value_bytes_seen;
        sval             = value_accum;
        // Sign-extend from the bytes gathered so far while fewer than four.
        if (held < 4 && value_accum[8*held-1]) sval = sval | (32'hFFFF_FFFF << (8 * held));
        last = (value_bytes_seen == cur_value_len);
        if (last) phase = AT_HEADER;
        return make_result(KIND_VALUE, MARK_NONE, cur_value_len, data, index, last,
                           value_accum, sval, length_fits(cur_value_len));
      end
      default: begin
        cur_tag          = {4'd0, data[7:4]};
        cur_context      = data[3];
        cur_len_code     = data[2:0];
        cur_value_len    = '0;
        value_bytes_seen = '0;
        value_accum      = '0;
        len_bytes_left   = '0;
        if (data[7:4] == EXT_TAG_NIBBLE) begin
          phase = AT_EXT_TAG;
          return make_result(KIND_HDR_PEND, MARK_NONE, '0, data, '0, 1'b0, '0, '0, 1'b0);
        end
        return apply_length_code(data);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Each result transfer is matched against the oldest awaited result.
  always @(posedge clk) begin
    thsd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_results.size() == 0) begin
        $error("result transfer with no decoded result awaited");
        mismatch_count++;
      end else begin
        want = decoded_results.pop_front();
        check_field("kind", want.kind, out_data.kind);
        check_field("tag_number", want.tag_number, out_data.tag_number);
        check_field("is_context", want.is_context, out_data.is_context);
        check_field("tag_mark", want.tag_mark, out_data.tag_mark);
        check_field("value_length", want.value_length, out_data.value_length);
        check_field("byte_out", want.byte_out, out_data.byte_out);
        check_field("value_index", want.value_index, out_data.value_index);
        check_field("last", want.last, out_data.last);
        check_field("uint_value", want.uint_value, out_data.uint_value);
        check_field("sint_value", want.sint_value, out_data.sint_value);
        check_field("value_fits", want.value_fits, out_data.value_fits);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one byte, with random idle cycles ahead of it, and decodes it once
  // the transfer has taken place.
  task automatic send_byte(input logic [7:0] data, input logic restart);
    thsd_in_t item;
    item.data_byte = data;
    item.restart   = restart;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decoded_results.push_back(decode_byte(item));
    bytes_sent++;
  endtask

  // Holds the input off until every decoded result has been transferred.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
  endtask

  // Sends one whole tag. Value bytes follow for as long as the model is in
  // the value phase; a cut_after of zero or more abandons the value early.
  task automatic send_tag(input logic [7:0] tag, input logic ctx, input logic [2:0] code,
                          input logic [1:0] len_form, input logic [31:0] length,
                          input logic force_restart, input int cut_after);
    logic [3:0] nibble;
    int         values;
    nibble = (tag < 8'd15) ? tag[3:0] : EXT_TAG_NIBBLE;
    send_byte({nibble, ctx, code}, force_restart || (phase != AT_HEADER));
    if (nibble == EXT_TAG_NIBBLE) send_byte(tag, 1'b0);
    if (phase == AT_LEN_BYTE) begin
      case (len_form)
        FORM_TWO: begin
          send_byte(LEN_TWO_BYTES, 1'b0);
          send_byte(length[15:8], 1'b0);
          send_byte(length[7:0], 1'b0);
        end
        FORM_FOUR: begin
          send_byte(LEN_FOUR_BYTES, 1'b0);
          send_byte(length[31:24], 1'b0);
          send_byte(length[23:16], 1'b0);
          send_byte(length[15:8], 1'b0);
          send_byte(length[7:0], 1'b0);
        end
        default: begin
          send_byte(length[7:0], 1'b0);
        end
      endcase
    end
    values = 0;
    while (phase == AT_VALUE && values != cut_after) begin
      send_byte(8'($urandom_range(255)), 1'b0);
      values++;
    end
  endtask

  // A tag with random content; most lengths are short, a few are long.
  task automatic send_random_tag(input int cut_pct);
    logic [7:0]  tag;
    logic        ctx;
    logic [2:0]  code;
    logic [1:0]  len_form;
    logic [31:0] length;
    int          pick;
    int          cut_after;
    ctx  = 1'($urandom_range(1));
    code = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 8) begin
      tag = BOOLEAN_TAG;
      ctx = 1'b0;
    end else if (pick < 28) begin
      tag = 8'($urandom_range(255));
    end else begin
      tag = 8'($urandom_range(14));
    end
    pick = $urandom_range(99);
    if (pick < 60) begin
      len_form = FORM_BYTE;
      pick     = $urandom_range(99);
      if (pick < 70)      length = $urandom_range(8);
      else if (pick < 96) length = $urandom_range(40);
      else                length = $urandom_range(253);
    end else if (pick < 80) begin
      len_form = FORM_TWO;
      length   = ($urandom_range(99) < 97) ? $urandom_range(12) : $urandom_range(600, 254);
    end else begin
      len_form = FORM_FOUR;
      length   = ($urandom_range(99) < 95) ? $urandom_range(12) : $urandom_range(300);
    end
    cut_after = ($urandom_range(99) < cut_pct) ? int'($urandom_range(3)) : -1;
    send_tag(tag, ctx, code, len_form, length, $urandom_range(99) < 10, cut_after);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_special_cases();
    // Application boolean, true then false.
    send_byte(8'h11, 1'b1);
    send_byte(8'h10, 1'b0);
    // Opening and closing context tags.
    send_byte(8'h3E, 1'b0);
    send_byte(8'h3F, 1'b0);
    // Application codes six and seven are errors.
    send_byte(8'h26, 1'b0);
    send_byte(8'h27, 1'b0);
    // Extended context tag with a one-byte negative value.
    send_byte(8'hF9, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h80, 1'b0);
    // Extended application tag one is still a boolean.
    send_byte(8'hF1, 1'b0);
    send_byte(BOOLEAN_TAG, 1'b0);
    // Zero length given in a length byte.
    send_byte(8'h25, 1'b0);
    send_byte(8'h00, 1'b0);
    // Two-byte extended length of two, then the value.
    send_byte(8'h2D, 1'b0);
    send_byte(LEN_TWO_BYTES, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // A restart in the middle of a value drops it.
    send_byte(8'h44, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h21, 1'b1);
    send_byte(8'hFF, 1'b0);
    // Extreme bytes: empty tag zero, then closing extended tag 255.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_for_results();
  endtask

  task automatic test_well_formed_streams();
    int stop_at;
    stop_at = bytes_sent + 1300;
    while (bytes_sent < stop_at) send_random_tag(0);
    wait_for_results();
  endtask

  task automatic test_without_idling();
    int stop_at;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    stop_at            = bytes_sent + 300;
    while (bytes_sent < stop_at) send_random_tag(0);
    sender_idle_pct    = IDLE_PCT;
    receiver_stall_pct = IDLE_PCT;
  endtask

  // Stray bytes, random restarts and abandoned values between good tags.
  task automatic test_broken_streams();
    int stop_at;
    stop_at = bytes_sent + 350;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 40) send_byte(8'($urandom_range(255)), $urandom_range(99) < 15);
      else send_random_tag(30);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_well_formed_streams();
    test_without_idling();
    test_broken_streams();
    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a stalled handshake.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
